[rtl/pcpo_pkg.sv]
// pcpo_pkg: shared types, register codes and step functions for the
// point collision push-out pipeline
// no dependencies

package pcpo_pkg;

  localparam int NAX        = 3;
  localparam int SQRT_STEPS = 31;
  localparam int DIV_STEPS  = 31;

  typedef logic signed [31:0] q16_t;

  typedef enum logic [2:0] {
    REG_CX  = 3'd0,
    REG_CY  = 3'd1,
    REG_CZ  = 3'd2,
    REG_RAD = 3'd3,
    REG_NX  = 3'd4,
    REG_NY  = 3'd5,
    REG_NZ  = 3'd6,
    REG_OFS = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    q16_t [2:0]        pos;
    q16_t [2:0]        vel;
    logic [2:0][30:0]  mag;
    logic [2:0]        dneg;
    logic              pinned;
    logic              last;
    logic              hs;
    logic              hp;
  } item_t;

  typedef struct packed {
    logic [32:0] rem;
    logic [30:0] root;
    logic [61:0] rad;
  } sqrt_st_t;

  typedef struct packed {
    logic [30:0] rem;
    logic [30:0] q;
    logic [30:0] nb;
  } div_st_t;

  function automatic q16_t sat32(input logic signed [35:0] v);
    if (v > 36'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -36'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

  // one root bit per step
  function automatic sqrt_st_t sqrt_step(input sqrt_st_t s);
    sqrt_st_t    o;
    logic [34:0] acc;
    logic [34:0] trial;
    logic [34:0] dif;
    acc   = {s.rem, s.rad[61:60]};
    trial = {2'b00, s.root, 2'b01};
    dif   = acc - trial;
    o.rad = {s.rad[59:0], 2'b00};
    if (acc >= trial) begin
      o.rem  = dif[32:0];
      o.root = {s.root[29:0], 1'b1};
    end else begin
      o.rem  = acc[32:0];
      o.root = {s.root[29:0], 1'b0};
    end
    return o;
  endfunction

  // one quotient bit per step
  function automatic div_st_t div_step(input div_st_t s, input logic [30:0] len);
    div_st_t     o;
    logic [31:0] acc;
    logic [31:0] dif;
    acc  = {s.rem, s.nb[30]};
    dif  = acc - {1'b0, len};
    o.nb = {s.nb[29:0], 1'b0};
    if (acc >= {1'b0, len}) begin
      o.rem = dif[30:0];
      o.q   = {s.q[29:0], 1'b1};
    end else begin
      o.rem = acc[30:0];
      o.q   = {s.q[29:0], 1'b0};
    end
    return o;
  endfunction

endpackage

[rtl/point_collision_push_out.sv]
// Cloth point collision response against one sphere and one plane, signed Q16.16,
// fully pipelined: one point enters per clock while the output is not stalled, the depth
// being set mostly by the 31-step square root and the 31-step radial divider.
// The whole pipeline advances together and holds only while the output beat waits
// under stall. Configuration registers are plain writes; change them only when idle.
// Depends on pcpo_pkg.

module point_collision_push_out import pcpo_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  q16_t        pos_x,
  input  q16_t        pos_y,
  input  q16_t        pos_z,
  input  q16_t        vel_x,
  input  q16_t        vel_y,
  input  q16_t        vel_z,
  input  logic        pinned,
  input  logic        last_point,
  output logic        out_valid,
  input  logic        out_stall,
  output q16_t        new_pos_x,
  output q16_t        new_pos_y,
  output q16_t        new_pos_z,
  output q16_t        new_vel_x,
  output q16_t        new_vel_y,
  output q16_t        new_vel_z,
  output logic        hit_sphere,
  output logic        hit_plane,
  output logic        frame_end,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // configuration
  q16_t [2:0]  ctr;
  q16_t [2:0]  nrm;
  logic [30:0] radius;
  q16_t        offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctr    <= '0;
      nrm    <= '0;
      radius <= '0;
      offset <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_CX:  ctr[0] <= cfg_data;
        REG_CY:  ctr[1] <= cfg_data;
        REG_CZ:  ctr[2] <= cfg_data;
        REG_RAD: radius <= cfg_data[30:0];
        REG_NX:  nrm[0] <= cfg_data;
        REG_NY:  nrm[1] <= cfg_data;
        REG_NZ:  nrm[2] <= cfg_data;
        REG_OFS: offset <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 1: offsets to centre
  q16_t [2:0]       in_pos;
  q16_t [2:0]       in_vel;
  logic [2:0][32:0] dv_c;
  logic [2:0][32:0] dabs_c;
  logic             near_c;
  item_t            in_it;

  assign in_pos = {pos_z, pos_y, pos_x};
  assign in_vel = {vel_z, vel_y, vel_x};

  always_comb begin
    near_c = 1'b1;
    in_it  = '0;
    in_it.pos    = in_pos;
    in_it.vel    = in_vel;
    in_it.pinned = pinned;
    in_it.last   = last_point;
    for (int i = 0; i < NAX; i++) begin
      dv_c[i]   = {ctr[i][31], ctr[i]} - {in_pos[i][31], in_pos[i]};
      dabs_c[i] = dv_c[i][32] ? (33'd0 - dv_c[i]) : dv_c[i];
      if (dabs_c[i] > {2'b00, radius}) near_c = 1'b0;
      in_it.mag[i]  = dabs_c[i][30:0];
      in_it.dneg[i] = dv_c[i][32];
    end
  end

  logic  v1, near1;
  item_t it1;

  // stage 2: squares
  logic             v2, near2;
  item_t            it2;
  logic [2:0][61:0] sq2;
  logic [61:0]      rr2;

  // stage 3: squared length
  logic        v3, near3;
  item_t       it3;
  logic [63:0] len2_3;
  logic [61:0] rr3;
  item_t       it3h;

  always_comb begin
    it3h    = it3;
    it3h.hs = near3 && (radius != '0) && (len2_3 != '0) && (len2_3 <= {2'b00, rr3})
              && !it3.pinned;
  end

  // square root
  logic     sq_v  [SQRT_STEPS+1];
  item_t    sq_it [SQRT_STEPS+1];
  sqrt_st_t sq_s  [SQRT_STEPS+1];

  // stage 5: shortfall to surface
  logic        v5;
  item_t       it5;
  logic [30:0] len5;
  logic [30:0] diff5;
  logic [2:0][61:0] num_c;

  always_comb begin
    for (int i = 0; i < NAX; i++) begin
      num_c[i] = 62'(it5.mag[i]) * 62'(diff5);
    end
  end

  // radial divide
  logic           dv_v  [DIV_STEPS+1];
  item_t          dv_it [DIV_STEPS+1];
  logic [30:0]    dv_len[DIV_STEPS+1];
  div_st_t [2:0]  dv_s  [DIV_STEPS+1];

  // stage 7: sphere push
  item_t                   sph_c;
  logic signed [2:0][35:0] spush_c;

  always_comb begin
    sph_c = dv_it[DIV_STEPS];
    for (int i = 0; i < NAX; i++) begin
      spush_c[i] = dv_it[DIV_STEPS].dneg[i] ?
                   (36'sd0 - $signed({5'b0, dv_s[DIV_STEPS][i].q})) :
                   $signed({5'b0, dv_s[DIV_STEPS][i].q});
      if (dv_it[DIV_STEPS].hs) begin
        sph_c.pos[i] = sat32($signed({{4{sph_c.pos[i][31]}}, sph_c.pos[i]})
                             - $signed(spush_c[i]));
        sph_c.vel[i] = sat32($signed({{4{sph_c.vel[i][31]}}, sph_c.vel[i]})
                             - $signed(spush_c[i]));
      end
    end
  end

  logic  v7;
  item_t it7;

  // stage 8: plane products
  logic              v8;
  item_t             it8;
  logic signed [63:0] dp8 [NAX];

  // stage 9, 10: dot sum
  logic               v9, v10;
  item_t              it9, it10;
  logic signed [64:0] sa9, sb9;
  logic signed [65:0] dot10;

  // stage 11: penetration depth
  logic        v11;
  item_t       it11;
  logic [47:0] e11;
  logic [50:0] ef_c;
  item_t       it10h;

  always_comb begin
    ef_c     = 51'd0 - {dot10[65], dot10[65:16]};
    it10h    = it10;
    it10h.hp = dot10[65] && !it10.pinned;
  end

  // stage 12: partial products
  logic             v12;
  item_t            it12;
  logic [2:0][55:0] ph12, pl12;
  logic [2:0][31:0] nabs_c;

  always_comb begin
    for (int i = 0; i < NAX; i++) begin
      nabs_c[i] = nrm[i][31] ? (32'd0 - nrm[i]) : nrm[i];
    end
  end

  // stage 13: push magnitude
  logic             v13;
  item_t            it13;
  logic [2:0][33:0] pc13;
  logic [2:0][79:0] full_c;
  logic [2:0][63:0] pw_c;

  always_comb begin
    for (int i = 0; i < NAX; i++) begin
      full_c[i] = {ph12[i], 24'h0} + 80'(pl12[i]);
      pw_c[i]   = full_c[i][79:16];
    end
  end

  // stage 14: plane push
  item_t                   fin_c;
  logic signed [2:0][35:0] ppush_c;

  always_comb begin
    fin_c = it13;
    for (int i = 0; i < NAX; i++) begin
      ppush_c[i] = nrm[i][31] ? (36'sd0 - $signed({2'b0, pc13[i]})) :
                   $signed({2'b0, pc13[i]});
      if (it13.hp) begin
        fin_c.pos[i] = sat32($signed({{4{it13.pos[i][31]}}, it13.pos[i]})
                             + $signed(ppush_c[i]));
        fin_c.vel[i] = sat32($signed({{4{it13.vel[i][31]}}, it13.vel[i]})
                             + $signed(ppush_c[i]));
      end
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      sq_v[0]   <= 1'b0;
      v5        <= 1'b0;
      dv_v[0]   <= 1'b0;
      v7        <= 1'b0;
      v8        <= 1'b0;
      v9        <= 1'b0;
      v10       <= 1'b0;
      v11       <= 1'b0;
      v12       <= 1'b0;
      v13       <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      sq_v[0]   <= v3;
      v5        <= sq_v[SQRT_STEPS];
      dv_v[0]   <= v5;
      v7        <= dv_v[DIV_STEPS];
      v8        <= v7;
      v9        <= v8;
      v10       <= v9;
      v11       <= v10;
      v12       <= v11;
      v13       <= v12;
      out_valid <= v13;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (adv) begin
      it1   <= in_it;
      near1 <= near_c;

      it2   <= it1;
      near2 <= near1;
      for (int i = 0; i < NAX; i++) begin
        sq2[i] <= 62'(it1.mag[i]) * 62'(it1.mag[i]);
      end
      rr2 <= 62'(radius) * 62'(radius);

      it3    <= it2;
      near3  <= near2;
      len2_3 <= 64'(sq2[0]) + 64'(sq2[1]) + 64'(sq2[2]);
      rr3    <= rr2;

      sq_it[0] <= it3h;
      sq_s[0]  <= '{rem: '0, root: '0, rad: len2_3[61:0]};

      it5   <= sq_it[SQRT_STEPS];
      len5  <= sq_s[SQRT_STEPS].root;
      diff5 <= radius - sq_s[SQRT_STEPS].root;

      dv_it[0]  <= it5;
      dv_len[0] <= len5;
      for (int i = 0; i < NAX; i++) begin
        dv_s[0][i] <= '{rem: num_c[i][61:31], q: '0, nb: num_c[i][30:0]};
      end

      it7 <= sph_c;

      it8 <= it7;
      for (int i = 0; i < NAX; i++) begin
        dp8[i] <= $signed(nrm[i]) * $signed(it7.pos[i]);
      end

      it9 <= it8;
      sa9 <= 65'(dp8[0]) + 65'(dp8[1]);
      sb9 <= 65'(dp8[2]) + 65'($signed({offset, 16'h0}));

      it10  <= it9;
      dot10 <= 66'(sa9) + 66'(sb9);

      it11 <= it10h;
      e11  <= (ef_c[50:48] != 3'd0) ? {48{1'b1}} : ef_c[47:0];

      it12 <= it11;
      for (int i = 0; i < NAX; i++) begin
        ph12[i] <= 56'(nabs_c[i]) * 56'(e11[47:24]);
        pl12[i] <= 56'(nabs_c[i]) * 56'(e11[23:0]);
      end

      it13 <= it12;
      for (int i = 0; i < NAX; i++) begin
        pc13[i] <= (pw_c[i][63:33] != '0) ? {1'b0, {33{1'b1}}} : {1'b0, pw_c[i][32:0]};
      end

      new_pos_x  <= fin_c.pos[0];
      new_pos_y  <= fin_c.pos[1];
      new_pos_z  <= fin_c.pos[2];
      new_vel_x  <= fin_c.vel[0];
      new_vel_y  <= fin_c.vel[1];
      new_vel_z  <= fin_c.vel[2];
      hit_sphere <= fin_c.hs;
      hit_plane  <= fin_c.hp;
      frame_end  <= fin_c.last;
    end
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[k+1] <= 1'b0;
      end else if (adv) begin
        sq_v[k+1] <= sq_v[k];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        sq_s[k+1]  <= sqrt_step(sq_s[k]);
        sq_it[k+1] <= sq_it[k];
      end
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[k+1] <= 1'b0;
      end else if (adv) begin
        dv_v[k+1] <= dv_v[k];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_it[k+1]  <= dv_it[k];
        dv_len[k+1] <= dv_len[k];
        for (int i = 0; i < NAX; i++) begin
          dv_s[k+1][i] <= div_step(dv_s[k][i], dv_len[k]);
        end
      end
    end
  end

endmodule

[rtl/pcpo_checker.sv]
// pcpo_checker: port-level assertions for point_collision_push_out
// bound to the top level below; depends on pcpo_pkg

module pcpo_checker import pcpo_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input q16_t new_pos_x,
  input q16_t new_vel_x,
  input logic hit_sphere,
  input logic hit_plane,
  input logic frame_end
);

  // no beat comes out of reset
  a_rst_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid after reset");

  // input only stalls behind a waiting output beat
  a_stall_link: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("in_stall does not follow output backpressure");

  // a waiting output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(new_pos_x) && $stable(new_vel_x)
      && $stable(hit_sphere) && $stable(hit_plane) && $stable(frame_end))
    else $error("stalled output beat changed");

  // a valid input is never stalled while no output beat is present
  a_free_accept: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall || !in_valid)
    else $error("input stalled with empty output");

endmodule

bind point_collision_push_out pcpo_checker u_pcpo_checker (.*);

[bench/testbench.sv]
// testbench for point_collision_push_out: random and directed cloth points against
// several sphere/plane settings, checked by a self-contained Q16.16 predictor
// depends on pcpo_pkg and the point_collision_push_out rtl
`timescale 1ns / 1ps

module testbench;
  import pcpo_pkg::*;

  typedef struct {
    q16_t pos [3];
    q16_t vel [3];
    logic pin;
    logic last;
  } point_t;

  typedef struct {
    q16_t pos [3];
    q16_t vel [3];
    logic hs;
    logic hp;
    logic fe;
  } push_t;

  localparam longint unsigned PUSH_CAP = 64'd1 << 34;

  class push_board;
    q16_t        ctr [3];
    q16_t        nrm [3];
    q16_t        ofs;
    logic [30:0] rad;
    push_t       pending_q [$];
    int          errors;
    int          beats_in;
    int          beats_out;
    int          sphere_hits;
    int          plane_hits;

    function void set_reg(cfg_reg_t idx, logic [31:0] d);
      case (idx)
        REG_CX: ctr[0] = d;
        REG_CY: ctr[1] = d;
        REG_CZ: ctr[2] = d;
        REG_RAD: rad = d[30:0];
        REG_NX: nrm[0] = d;
        REG_NY: nrm[1] = d;
        REG_NZ: nrm[2] = d;
        REG_OFS: ofs = d;
        default: ;
      endcase
    endfunction

    function longint clamp32(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
    endfunction

    function longint unsigned absu(longint x);
      return x < 0 ? longint'(-x) : x;
    endfunction

    function longint unsigned root_floor(longint unsigned x);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function longint unsigned plane_push(longint unsigned n, longint unsigned e);
      longint unsigned eh;
      longint unsigned el;
      longint unsigned m;
      eh = e >> 16;
      el = e & 64'hffff;
      if (eh != 0 && n > PUSH_CAP / eh) return PUSH_CAP;
      m = n * eh + ((n * el) >> 16);
      return m > PUSH_CAP ? PUSH_CAP : m;
    endfunction

    function push_t respond(point_t a);
      push_t           o;
      longint          p [3];
      longint          v [3];
      longint          dv [3];
      longint unsigned r;
      longint unsigned len2;
      longint unsigned len;
      longint unsigned diff;
      longint          push;
      longint          prod;
      longint          hi;
      longint          hsum;
      longint          lsum;
      bit              near;
      o.hs = 0;
      o.hp = 0;
      for (int i = 0; i < 3; i++) begin
        p[i] = a.pos[i];
        v[i] = a.vel[i];
      end
      if (!a.pin) begin
        r = rad;
        near = 1;
        for (int i = 0; i < 3; i++) begin
          dv[i] = longint'(ctr[i]) - p[i];
          if (absu(dv[i]) > r) near = 0;
        end
        if (near && r != 0) begin
          len2 = 0;
          for (int i = 0; i < 3; i++) len2 += absu(dv[i]) * absu(dv[i]);
          if (len2 != 0 && len2 <= r * r) begin
            len = root_floor(len2);
            diff = r - len;
            o.hs = 1;
            for (int i = 0; i < 3; i++) begin
              push = longint'((absu(dv[i]) * diff) / len);
              if (dv[i] < 0) push = -push;
              p[i] = clamp32(p[i] - push);
              v[i] = clamp32(v[i] - push);
            end
          end
        end
        hsum = ofs;
        lsum = 0;
        for (int i = 0; i < 3; i++) begin
          prod = longint'(nrm[i]) * p[i];
          hi = prod >>> 16;
          hsum += hi;
          lsum += prod - hi * 65536;
        end
        hsum += lsum / 65536;
        if (hsum < 0) begin
          o.hp = 1;
          for (int i = 0; i < 3; i++) begin
            push = longint'(plane_push(absu(nrm[i]), longint'(-hsum)));
            if (nrm[i] < 0) push = -push;
            p[i] = clamp32(p[i] + push);
            v[i] = clamp32(v[i] + push);
          end
        end
      end
      for (int i = 0; i < 3; i++) begin
        o.pos[i] = p[i][31:0];
        o.vel[i] = v[i][31:0];
      end
      o.fe = a.last;
      return o;
    endfunction

    function void note_point(point_t a);
      push_t e;
      e = respond(a);
      beats_in++;
      sphere_hits += e.hs;
      plane_hits += e.hp;
      pending_q.push_back(e);
    endfunction

    function void check_result(push_t act);
      push_t e;
      bit    bad;
      beats_out++;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("result beat with nothing expected at %0t", $realtime);
        return;
      end
      e = pending_q.pop_front();
      bad = (e.hs != act.hs) || (e.hp != act.hp) || (e.fe != act.fe);
      for (int i = 0; i < 3; i++)
        if (e.pos[i] != act.pos[i] || e.vel[i] != act.vel[i]) bad = 1;
      if (bad) begin
        errors++;
        if (errors <= 10) begin
          $display("bad result beat %0d at %0t", beats_out, $realtime);
          $display("  exp pos %h %h %h vel %h %h %h hs %b hp %b fe %b", e.pos[0], e.pos[1],
                   e.pos[2], e.vel[0], e.vel[1], e.vel[2], e.hs, e.hp, e.fe);
          $display("  got pos %h %h %h vel %h %h %h hs %b hp %b fe %b", act.pos[0],
                   act.pos[1], act.pos[2], act.vel[0], act.vel[1], act.vel[2], act.hs,
                   act.hp, act.fe);
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  q16_t        pos_x, pos_y, pos_z, vel_x, vel_y, vel_z;
  logic        pinned;
  logic        last_point;
  logic        out_valid;
  logic        out_stall;
  q16_t        new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z;
  logic        hit_sphere;
  logic        hit_plane;
  logic        frame_end;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  push_board board;
  int        send_idle_pct;
  int        stall_pct;
  int        hold_req;
  int        hold_seen;
  int        hold_cnt;

  point_collision_push_out dut (.*);

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("point_collision_push_out: mismatch");
    $finish;
  end

  // receiver side: random stalls plus long hold-offs on request
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_cnt = 400;
    end
    if (hold_cnt > 0) begin
      hold_cnt = hold_cnt - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    point_t a;
    push_t  r;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        a.pos = '{pos_x, pos_y, pos_z};
        a.vel = '{vel_x, vel_y, vel_z};
        a.pin = pinned;
        a.last = last_point;
        board.note_point(a);
      end
      if (out_valid && !out_stall) begin
        r.pos = '{new_pos_x, new_pos_y, new_pos_z};
        r.vel = '{new_vel_x, new_vel_y, new_vel_z};
        r.hs = hit_sphere;
        r.hp = hit_plane;
        r.fe = frame_end;
        board.check_result(r);
      end
    end
  end

  task automatic send_point(point_t a);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    pos_x <= a.pos[0];
    pos_y <= a.pos[1];
    pos_z <= a.pos[2];
    vel_x <= a.vel[0];
    vel_y <= a.vel[1];
    vel_z <= a.vel[2];
    pinned <= a.pin;
    last_point <= a.last;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain(int extra);
    int waited;
    waited = 0;
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending_q.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_regs(q16_t c [3], logic [30:0] r, q16_t n [3], q16_t d);
    logic [31:0] vals [8];
    vals = '{c[0], c[1], c[2], {1'b0, r}, n[0], n[1], n[2], d};
    for (int i = 0; i < 8; i++) begin
      @(negedge clk);
      cfg_we <= 1'b1;
      cfg_index <= i[2:0];
      cfg_data <= vals[i];
      board.set_reg(cfg_reg_t'(i), vals[i]);
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic point_t mk(q16_t px, q16_t py, q16_t pz, q16_t vx, q16_t vy, q16_t vz,
                                logic pin, logic last);
    point_t a;
    a.pos = '{px, py, pz};
    a.vel = '{vx, vy, vz};
    a.pin = pin;
    a.last = last;
    return a;
  endfunction

  function automatic q16_t scaled_rand();
    return $signed($urandom) >>> $urandom_range(31, 0);
  endfunction

  function automatic point_t random_point();
    point_t a;
    longint off;
    int     kind;
    kind = $urandom_range(9);
    for (int i = 0; i < 3; i++) begin
      if (kind < 5) begin
        off = longint'($urandom) % (longint'(board.rad) + longint'(board.rad >> 2) + 1);
        if ($urandom_range(1)) off = -off;
        a.pos[i] = q16_t'(board.clamp32(longint'(board.ctr[i]) + off));
      end else if (kind < 8) begin
        a.pos[i] = scaled_rand();
      end else begin
        a.pos[i] = $urandom;
      end
      a.vel[i] = $urandom_range(1) ? q16_t'($urandom) : scaled_rand();
    end
    a.pin = ($urandom_range(7) == 0);
    a.last = ($urandom_range(15) == 0);
    return a;
  endfunction

  initial begin
    q16_t        c [3];
    q16_t        n [3];
    logic [30:0] r;
    q16_t        d;
    int          axis;
    board = new();
    rst = 1'b1;
    in_valid = 1'b0;
    pos_x = '0; pos_y = '0; pos_z = '0;
    vel_x = '0; vel_y = '0; vel_z = '0;
    pinned = 1'b0;
    last_point = 1'b0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_req = 0;
    hold_seen = 0;
    hold_cnt = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // sphere of radius 2 at origin, floor plane y = -1
    write_regs('{0, 0, 0}, 31'h20000, '{0, 32'h10000, 0}, 32'h10000);
    send_point(mk(0, 0, 0, 32'h100, 0, 0, 0, 0));
    send_point(mk(32'h8000, 32'h4000, 0, 0, 0, 0, 0, 0));
    send_point(mk(32'h20000, 0, 0, 1, 2, 3, 0, 0));
    send_point(mk(32'h20001, 0, 0, 0, 0, 0, 0, 0));
    send_point(mk(32'h18000, 32'h18000, 0, 0, 0, 0, 0, 0));
    send_point(mk(32'h8000, 32'h4000, 0, 5, 5, 5, 1, 0));
    send_point(mk(0, -32'sh40000, 0, 0, 0, 0, 0, 0));
    send_point(mk(0, 32'h80000000, 0, 0, 32'h80000000, 0, 0, 0));
    send_point(mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                  32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 1));
    send_point(mk(32'h80000000, 32'h80000000, 32'h80000000,
                  32'h80000000, 32'h80000000, 32'h80000000, 0, 0));
    send_point(mk(32'h80000000, 32'h80000000, 32'h80000000,
                  32'h80000000, 32'h80000000, 32'h80000000, 1, 1));
    send_point(mk(-32'sh1, 32'h1, -32'sh1, 32'h7fffffff, 32'h80000000, 0, 0, 0));
    send_point(mk(0, -32'sh10001, 0, 0, 0, 0, 0, 1));
    drain(100);
    // extreme settings: huge sphere, negative normals and offsets
    write_regs('{32'h7fffffff, 32'h80000000, 32'h7fffffff}, 31'h7fffffff,
               '{32'h80000000, 32'h7fffffff, 32'h80000000}, 32'h80000000);
    send_point(mk(0, 0, 0, 0, 0, 0, 0, 0));
    send_point(mk(32'h7fffffff, 32'h80000000, 32'h7fffffff, 1, 1, 1, 0, 0));
    send_point(mk(32'h7fff0000, 32'h80010000, 32'h7ffe0000, 32'h7fffffff,
                  32'h80000000, 0, 0, 1));
    send_point(mk(32'h80000000, 32'h7fffffff, 32'h80000000, 0, 0, 0, 0, 0));
    send_point(mk(32'h12345678, 32'hedcba987, 0, 0, 0, 0, 1, 0));
    drain(100);

    for (int ph = 0; ph < 10; ph++) begin
      if (ph == 3) begin
        write_regs('{32'h7fffffff, 32'h7fffffff, 32'h80000000}, 31'h7fffffff,
                   '{32'h7fffffff, 32'h80000000, 32'h7fffffff}, 32'h7fffffff);
      end else if (ph == 6) begin
        write_regs('{0, 0, 0}, 31'h1, '{0, 0, 0}, 0);
      end else if (ph == 8) begin
        write_regs('{0, 0, 0}, 31'h0, '{0, 0, 32'h10000}, 0);
      end else begin
        for (int i = 0; i < 3; i++) begin
          c[i] = $signed($urandom) >>> $urandom_range(31, 10);
          n[i] = 0;
        end
        r = 31'($urandom >> $urandom_range(1, 20));
        axis = $urandom_range(2);
        if ($urandom_range(2) == 0) begin
          for (int i = 0; i < 3; i++) n[i] = $signed($urandom) >>> $urandom_range(31, 14);
        end else begin
          n[axis] = $urandom_range(1) ? 32'sh10000 : -32'sh10000;
        end
        d = $signed($urandom) >>> $urandom_range(31, 8);
        write_regs(c, r, n, d);
      end
      case (ph % 4)
        0: begin send_idle_pct = 0; stall_pct = 0; end
        1: begin send_idle_pct = 79; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 79; end
        default: begin send_idle_pct = 18; stall_pct = 18; end
      endcase
      if (ph == 4) begin
        send_idle_pct = 0;
        stall_pct = 0;
        hold_req++;
      end
      for (int k = 0; k < 100; k++) begin
        if (ph == 5 && k == 50) drain(0);
        if (ph == 9 && k == 50) begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        send_point(random_point());
      end
      drain(100);
    end

    $display("points in %0d, results out %0d, sphere pushes %0d, plane pushes %0d",
             board.beats_in, board.beats_out, board.sphere_hits, board.plane_hits);
    $display("twelve register settings incl. extremes, all idle and stall mixes");
    if (board.pending_q.size() != 0) begin
      board.errors++;
      $display("%0d expected results never arrived", board.pending_q.size());
    end
    if (board.errors == 0) begin
      $display("point_collision_push_out: match");
    end else begin
      $display("point_collision_push_out: mismatch");
    end
    $finish;
  end

endmodule
